>>> rtl/core/polyline_length_and_chord_core_assert.svh
// Assertion macros shared by the polyline length checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef POLYLINE_LENGTH_AND_CHORD_CORE_ASSERT_SVH
`define POLYLINE_LENGTH_AND_CHORD_CORE_ASSERT_SVH

// Implication checked at every rising edge, quiet while reset is held.
`define PLC_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Same, but the consequent is checked in the cycle after the antecedent.
`define PLC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/core/plc_pkg.sv
// Shared types and constants for the polyline length and chord core.
// No dependencies; imported by every module of the block.
`default_nettype none

package plc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int SUM_W           = 40;
    localparam int SUM_EXT_W       = SUM_W + 1;
    localparam int CHORD_W         = 26;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CHORD_W-1:0] CHORD_MAX = {CHORD_W{1'b1}};

    // Top-level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG_GO,
        S_SEG_WAIT,
        S_CHD_GO,
        S_CHD_WAIT,
        S_OUT
    } plc_state_t;

    // Distance unit sequencer
    typedef enum logic [2:0] {
        D_IDLE,
        D_SQX,
        D_SQY,
        D_ROOT,
        D_DONE
    } dist_state_t;

    typedef struct packed {
        logic start;
    } dist_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dist_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/plc_dist.sv
// Iterative Euclidean distance unit: floor(sqrt(dx^2 + dy^2)).
// One shared squarer, then a restoring root, one result bit per cycle. Uses plc_pkg.
`default_nettype none

module plc_dist #(
    parameter int COORD_WIDTH = plc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire plc_pkg::dist_ctl_t            ctl,
    output plc_pkg::dist_sts_t                 sts,
    input  wire logic [COORD_WIDTH-1:0]        a_x,
    input  wire logic [COORD_WIDTH-1:0]        a_y,
    input  wire logic [COORD_WIDTH-1:0]        b_x,
    input  wire logic [COORD_WIDTH-1:0]        b_y,
    output logic      [COORD_WIDTH:0]          root
);
    import plc_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int SQ_W   = 2 * CW;
    localparam int RAD_W  = 2 * CW + 2;
    localparam int ROOT_W = CW + 1;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    dist_state_t state_reg, state_next;

    logic [CW-1:0]     dx_reg, dy_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [CW:0]       diff_x, diff_y, neg_x, neg_y;
    logic [CW-1:0]     abs_x, abs_y;
    logic [CW-1:0]     mul_a;
    logic [SQ_W-1:0]   mul_p;
    logic [REM_W-1:0]  rem_shift, trial, rem_sub;
    logic              take;

    assign diff_x = {a_x[CW-1], a_x} - {b_x[CW-1], b_x};
    assign diff_y = {a_y[CW-1], a_y} - {b_y[CW-1], b_y};
    assign neg_x  = ~diff_x + 1'b1;
    assign neg_y  = ~diff_y + 1'b1;
    assign abs_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
    assign abs_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];

    // Single squarer, shared between the two axes
    assign mul_a = (state_reg == D_SQX) ? dx_reg : dy_reg;
    assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_a);

    // One root bit per cycle: bring down the next bit pair, try 4*root+1
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);
    assign rem_sub   = rem_shift - trial;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = D_SQX;
                end
            end
            D_SQX:  state_next = D_SQY;
            D_SQY:  state_next = D_ROOT;
            D_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (ctl.start)
                begin
                    dx_reg <= abs_x;
                    dy_reg <= abs_y;
                end
            end
            D_SQX:
            begin
                sq_reg <= mul_p;
            end
            D_SQY:
            begin
                rad_reg  <= RAD_W'(sq_reg) + RAD_W'(mul_p);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            D_ROOT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= take ? rem_sub : rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], take};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.busy = (state_reg != D_IDLE);
    assign sts.done = (state_reg == D_DONE);
    assign root     = root_reg;

endmodule

`default_nettype wire

>>> rtl/core/polyline_length_and_chord_core.sv
// Polyline length and chord core: top level with the path sequencer and output register.
// Depends on plc_pkg and plc_dist.
//
// Usage: points enter on the in channel (x_coord, y_coord, last_point), signed Q16.8,
// one transfer per point. A transfer happens when in_valid is high and in_stall is low.
// Each point marked last_point gives one result on the out channel: path_length
// (Q32.8, saturating, with length_saturated), and chord_length, the first-to-last
// distance. A path of one point gives zero for both.
// Sequence, with R = COORD_WIDTH + 1 root bits (25 by default): the first point of a
// longer path is taken while the sequencer stays idle. Every later point needs one
// distance of R root bits, and a last point one more for the chord, then a load of
// the output register, before the next input transfer can happen.
// The rate is set by the single distance unit, which squares both axes on one
// multiplier and then develops the root one bit per cycle.
// in_stall is high whenever the sequencer is not idle. A finished result sits in
// the output register; the next point is taken while it waits, and only a further
// result holds the sequencer until out_stall drops.
// Reset clears the open path, the running sum and the output valid.
`default_nettype none

module polyline_length_and_chord_core #(
    parameter int COORD_WIDTH = plc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] y_coord,
    input  wire logic                          last_point,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [plc_pkg::SUM_W-1:0]          path_length,
    output logic [plc_pkg::CHORD_W-1:0]        chord_length,
    output logic                               length_saturated
);
    import plc_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int ROOT_W = CW + 1;

    plc_state_t state_reg, state_next;

    logic [CW-1:0]      first_x_reg, first_y_reg;
    logic [CW-1:0]      prev_x_reg, prev_y_reg;
    logic [CW-1:0]      cur_x_reg, cur_y_reg;
    logic               last_reg;
    logic               path_open_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               clip_reg;
    logic [CHORD_W-1:0] chord_reg;

    logic               out_valid_reg;
    logic [SUM_W-1:0]   path_length_reg;
    logic [CHORD_W-1:0] chord_length_reg;
    logic               length_sat_reg;

    logic               accept;
    logic               out_load;
    dist_ctl_t          dist_ctl;
    dist_sts_t          dist_sts;
    logic [CW-1:0]      op_x, op_y;
    logic [ROOT_W-1:0]  root;
    logic [SUM_EXT_W-1:0] sum_ext;
    logic [CHORD_W-1:0] chord_sat;
    logic               seg_done, chd_done;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Segment uses the previous point, chord the first point
    assign op_x = (state_reg == S_SEG_GO) ? prev_x_reg : first_x_reg;
    assign op_y = (state_reg == S_SEG_GO) ? prev_y_reg : first_y_reg;

    plc_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dist_ctl),
        .sts   (dist_sts),
        .a_x   (op_x),
        .a_y   (op_y),
        .b_x   (cur_x_reg),
        .b_y   (cur_y_reg),
        .root  (root)
    );

    assign sum_ext  = {1'b0, sum_reg} + SUM_EXT_W'(root);
    assign seg_done = (state_reg == S_SEG_WAIT) && dist_sts.done;
    assign chd_done = (state_reg == S_CHD_WAIT) && dist_sts.done;

    generate
        if (ROOT_W > CHORD_W)
        begin : g_chord_clip
            assign chord_sat = (|root[ROOT_W-1:CHORD_W]) ? CHORD_MAX : root[CHORD_W-1:0];
        end
        else
        begin : g_chord_fit
            assign chord_sat = CHORD_W'(root);
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        dist_ctl.start = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (path_open_reg)
                    begin
                        state_next = S_SEG_GO;
                    end
                    else if (last_point)
                    begin
                        state_next = S_CHD_GO;
                    end
                end
            end
            S_SEG_GO:
            begin
                if (!dist_sts.busy)
                begin
                    dist_ctl.start = 1'b1;
                    state_next     = S_SEG_WAIT;
                end
            end
            S_SEG_WAIT:
            begin
                if (dist_sts.done)
                begin
                    state_next = last_reg ? S_CHD_GO : S_IDLE;
                end
            end
            S_CHD_GO:
            begin
                if (!dist_sts.busy)
                begin
                    dist_ctl.start = 1'b1;
                    state_next     = S_CHD_WAIT;
                end
            end
            S_CHD_WAIT:
            begin
                if (dist_sts.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            path_open_reg <= 1'b0;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !path_open_reg)
            begin
                path_open_reg <= 1'b1;
                sum_reg       <= '0;
                clip_reg      <= 1'b0;
            end
            if (seg_done)
            begin
                if (sum_ext[SUM_W])
                begin
                    sum_reg  <= SUM_MAX;
                    clip_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_ext[SUM_W-1:0];
                end
            end
            if (chd_done)
            begin
                path_open_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg <= x_coord;
            cur_y_reg <= y_coord;
            last_reg  <= last_point;
            if (!path_open_reg)
            begin
                first_x_reg <= x_coord;
                first_y_reg <= y_coord;
                prev_x_reg  <= x_coord;
                prev_y_reg  <= y_coord;
            end
        end
        // distance unit has taken its operands: advance the previous point
        if (dist_ctl.start && (state_reg == S_SEG_GO))
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (chd_done)
        begin
            chord_reg <= chord_sat;
        end
        if (out_load)
        begin
            path_length_reg  <= sum_reg;
            chord_length_reg <= chord_reg;
            length_sat_reg   <= clip_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign path_length      = path_length_reg;
    assign chord_length     = chord_length_reg;
    assign length_saturated = length_sat_reg;

endmodule

`default_nettype wire

>>> rtl/core/plc_checker.sv
// Port-level checker for the polyline length and chord core, bound to the top level.
// Depends on plc_pkg and polyline_length_and_chord_core_assert.svh.
`default_nettype none

module plc_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic                        last_point,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic [plc_pkg::SUM_W-1:0]   path_length,
    input  wire logic [plc_pkg::CHORD_W-1:0] chord_length,
    input  wire logic                        length_saturated
);
    import plc_pkg::*;

`include "polyline_length_and_chord_core_assert.svh"

    // a stalled result holds its value
    `PLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(path_length) && $stable(chord_length) && $stable(length_saturated), "stalled result changed")

    // a last point always takes the chord pass, so the input closes next cycle
    `PLC_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && last_point, in_stall, "input open after last point")

    // a clipped sum reads as the maximum length
    `PLC_ASSERT_IMP(a_sat_max, out_valid && length_saturated, path_length == SUM_MAX, "saturated length not at maximum")

    // a new result is only loaded by the busy sequencer
    `PLC_ASSERT_IMP(a_load_busy, $rose(out_valid), $past(in_stall), "result loaded while idle")

endmodule

bind polyline_length_and_chord_core plc_checker u_plc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .last_point       (last_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .path_length      (path_length),
    .chord_length     (chord_length),
    .length_saturated (length_saturated)
);

`default_nettype wire

>>> verif/tb.sv
// Testbench for polyline_length_and_chord_core: streams points, predicts each closed path's
// length, chord and clip flag, and checks every result transfer in order.
// Depends on plc_pkg and the core RTL.

typedef logic signed [plc_pkg::COORD_WIDTH_DEF-1:0] coord_t;

class path_measure;
    typedef struct {
        logic [plc_pkg::SUM_W-1:0]   total;
        logic [plc_pkg::CHORD_W-1:0] chord;
        logic                        clipped;
    } path_result_t;

    coord_t                    first_x, first_y, prev_x, prev_y;
    logic [plc_pkg::SUM_W-1:0] run_sum;
    bit                        path_open, sum_clipped;
    path_result_t              due_paths[$];
    int                        fail_count;

    function new();
        first_x     = '0;
        first_y     = '0;
        prev_x      = '0;
        prev_y      = '0;
        run_sum     = '0;
        path_open   = 1'b0;
        sum_clipped = 1'b0;
        fail_count  = 0;
    endfunction

    // Floor square root, two radicand bits per pass.
    function logic [31:0] root_floor(logic [63:0] rad);
        logic [63:0] rem, root, trial;
        rem  = '0;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
            root  = root << 1;
            trial = (root << 1) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = root | 64'd1;
            end
        end
        return root[31:0];
    endfunction

    function logic [31:0] span(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        longint dx, dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return root_floor(dx * dx + dy * dy);
    endfunction

    function void note_point(coord_t x, coord_t y, logic end_flag);
        logic [31:0]  seg, chord;
        path_result_t r;
        if (!path_open)
        begin
            first_x     = x;
            first_y     = y;
            run_sum     = '0;
            sum_clipped = 1'b0;
            path_open   = 1'b1;
        end
        else
        begin
            seg = span(prev_x, prev_y, x, y);
            // Clip only when the sum would pass the ceiling, not when it lands on it
            if (seg > plc_pkg::SUM_MAX - run_sum)
            begin
                run_sum     = plc_pkg::SUM_MAX;
                sum_clipped = 1'b1;
            end
            else
                run_sum = run_sum + seg;
        end
        prev_x = x;
        prev_y = y;
        if (end_flag)
        begin
            chord = span(first_x, first_y, x, y);
            if (chord > plc_pkg::CHORD_MAX)
                chord = plc_pkg::CHORD_MAX;
            r.total   = run_sum;
            r.chord   = chord[plc_pkg::CHORD_W-1:0];
            r.clipped = sum_clipped;
            due_paths.push_back(r);
            path_open = 1'b0;
        end
    endfunction

    function int pending();
        return due_paths.size();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_path(logic [plc_pkg::SUM_W-1:0] total, logic [plc_pkg::CHORD_W-1:0] chord,
                    logic clipped);
        path_result_t want;
        if (due_paths.size() == 0)
        begin
            report("result with no path closed", total, 0);
            return;
        end
        want = due_paths.pop_front();
        if (total !== want.total)
            report("path_length", total, want.total);
        if (chord !== want.chord)
            report("chord_length", chord, want.chord);
        if (clipped !== want.clipped)
            report("length_saturated", clipped, want.clipped);
    endtask
endclass

module tb;
    localparam int     CW            = plc_pkg::COORD_WIDTH_DEF;
    localparam coord_t C_MIN         = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t C_MAX         = {1'b0, {(CW-1){1'b1}}};
    localparam int     RANDOM_POINTS = 1450;
    localparam int     SETTLE_CYCLES = 2 * (CW + 1) + 30;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    coord_t                        x_coord;
    coord_t                        y_coord;
    logic                          last_point;
    logic                          out_valid;
    logic                          out_stall;
    logic [plc_pkg::SUM_W-1:0]     path_length;
    logic [plc_pkg::CHORD_W-1:0]   chord_length;
    logic                          length_saturated;

    path_measure sb = new();

    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    int rx_hold_req = 0;
    int stall_left  = 0;

    polyline_length_and_chord_core #(
        .COORD_WIDTH(CW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .last_point(last_point),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .path_length(path_length),
        .chord_length(chord_length),
        .length_saturated(length_saturated)
    );

    always #5 clk = ~clk;

    initial
    begin
        #250_000_000;
        $display("Verification failed");
        $finish;
    end

    // Check each result transfer and draw the stall before the next one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_path(path_length, chord_length, length_saturated);
            stall_left = rx_quiet ? 0 : $urandom_range(0, 19);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_point(input coord_t x, input coord_t y, input logic end_flag);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        x_coord    <= x;
        y_coord    <= y;
        last_point <= end_flag;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_point(x, y, end_flag);
        @(negedge clk);
    endtask

    task automatic wait_paths_done();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic coord_t pick_coord(input coord_t near);
        case ($urandom_range(0, 6))
            0: return C_MIN;
            1: return C_MAX;
            2: return coord_t'(int'($urandom_range(0, 600)) - 300);
            3: return near + coord_t'(int'($urandom_range(0, 4000)) - 2000);
            default: return coord_t'($urandom);
        endcase
    endfunction

    initial
    begin
        int sent, plen;
        bit pressed, paused;
        sent       = 0;
        pressed    = 1'b0;
        paused     = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        x_coord    = '0;
        y_coord    = '0;
        last_point = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Lone points
        send_point(C_MIN, C_MAX, 1'b1);
        send_point('0, '0, 1'b1);
        // Widest diagonal, both as segment and chord
        send_point(C_MIN, C_MIN, 1'b0);
        send_point(C_MAX, C_MAX, 1'b1);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, 1'b1);
        // Repeated point: zero segments and a zero chord
        send_point(coord_t'(5), coord_t'(-7), 1'b0);
        send_point(coord_t'(5), coord_t'(-7), 1'b0);
        send_point(coord_t'(5), coord_t'(-7), 1'b1);
        // Exact 3-4-5 segment, then a return near the start
        send_point('0, '0, 1'b0);
        send_point(coord_t'(768), coord_t'(1024), 1'b0);
        send_point(coord_t'(-1), coord_t'(-1), 1'b1);
        // Alternating bit patterns on both axes
        send_point({(CW/2){2'b10}}, {(CW/2){2'b01}}, 1'b0);
        send_point({(CW/2){2'b01}}, {(CW/2){2'b10}}, 1'b1);
        // Sub-unit diagonal, root rounds down
        send_point(coord_t'(1), '0, 1'b0);
        send_point('0, coord_t'(1), 1'b1);
        send_point(C_MAX, '0, 1'b1);
        wait_paths_done();

        while (sent < RANDOM_POINTS)
        begin
            if ($urandom_range(0, 40) == 0)
            begin
                tx_quiet = ($urandom_range(0, 2) == 0);
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
            if (!pressed && sent >= 600)
            begin
                // Hold the output off and offer 20 points in short paths, so that the core backs up
                pressed     = 1'b1;
                rx_hold_req = 400;
                tx_quiet    = 1'b1;
                for (int k = 0; k < 20; k++)
                begin
                    send_point(pick_coord(sb.prev_x), pick_coord(sb.prev_y),
                               1'($urandom_range(0, 1)));
                    sent++;
                end
                tx_quiet = 1'b0;
            end
            if (!paused && sent >= 1000)
            begin
                paused = 1'b1;
                wait_paths_done();
            end
            plen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
            for (int k = 0; k < plen; k++)
            begin
                send_point(pick_coord(sb.prev_x), pick_coord(sb.prev_y), k == plen - 1);
                sent++;
            end
        end

        wait_paths_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
